>>> rtl/qrm_pkg.sv
package qrm_pkg;

    localparam int FRAC_BITS = 14;
    localparam int NL        = 9;                // matrix entries
    localparam int IW        = 16;               // input component width
    localparam int PW        = 2 * IW;           // product width
    localparam int SW        = PW + 3;           // signed numerator width
    localparam int MW        = PW + 2;           // magnitude / remainder width
    localparam int QW        = FRAC_BITS + 2;    // quotient bits, one extra for rounding
    localparam int OW        = 16;               // output entry width
    localparam int EW        = (FRAC_BITS + 3 > OW + 1) ? FRAC_BITS + 3 : OW + 1;
    localparam int DIV_STEPS = FRAC_BITS + 1;    // steps after the integer bit

    typedef logic signed [OW-1:0] entry_t;

    typedef struct packed {
        logic [NL-1:0]          neg;
        logic [NL-1:0][MW-1:0]  rem;
        logic [NL-1:0][QW-1:0]  quo;
        logic [MW-1:0]          norm;
        logic                   degen;
    } div_t;

    function automatic entry_t sat_entry(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] one_v;
        logic signed [EW-1:0] hi;
        logic signed [EW-1:0] lo;
        logic signed [EW-1:0] t;
        one_v = signed'(EW'(1)) <<< FRAC_BITS;
        hi    = signed'(EW'(32767));
        lo    = -signed'(EW'(32768));
        t     = v;
        if (t > one_v)
        begin
            t = one_v;
        end
        if (t < -one_v)
        begin
            t = -one_v;
        end
        if (t > hi)
        begin
            t = hi;
        end
        if (t < lo)
        begin
            t = lo;
        end
        return t[OW-1:0];
    endfunction

    localparam entry_t IDENT_ONE = sat_entry(signed'(EW'(1)) <<< FRAC_BITS);

endpackage

>>> rtl/qrm_front.sv
module qrm_front
    import qrm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [IW-1:0] qw,
    input  logic signed [IW-1:0] qx,
    input  logic signed [IW-1:0] qy,
    input  logic signed [IW-1:0] qz,
    output logic                 out_valid,
    output div_t                 out_data
);

    // stage 1: products
    logic signed [PW-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PW-1:0] xy_reg, xz_reg, yz_reg, xw_reg, yw_reg, zw_reg;
    logic                 v1_reg;

    // stage 2: numerators and norm
    logic signed [SW-1:0] num_reg [NL];
    logic signed [SW-1:0] num_next [NL];
    logic [MW-1:0]        norm_reg, norm_next;
    logic                 v2_reg;

    // stage 3: sign split and integer quotient bit
    div_t                 d3_reg, d3_next;
    logic                 v3_reg;

    logic [MW-1:0]        mag [NL];

    always_comb
    begin
        norm_next = MW'(ww_reg) + MW'(xx_reg) + MW'(yy_reg) + MW'(zz_reg);
        num_next[0] = SW'(ww_reg) + SW'(xx_reg) - SW'(yy_reg) - SW'(zz_reg);
        num_next[1] = (SW'(xy_reg) + SW'(zw_reg)) <<< 1;
        num_next[2] = (SW'(xz_reg) - SW'(yw_reg)) <<< 1;
        num_next[3] = (SW'(xy_reg) - SW'(zw_reg)) <<< 1;
        num_next[4] = SW'(ww_reg) - SW'(xx_reg) + SW'(yy_reg) - SW'(zz_reg);
        num_next[5] = (SW'(yz_reg) + SW'(xw_reg)) <<< 1;
        num_next[6] = (SW'(xz_reg) + SW'(yw_reg)) <<< 1;
        num_next[7] = (SW'(yz_reg) - SW'(xw_reg)) <<< 1;
        num_next[8] = SW'(ww_reg) - SW'(xx_reg) - SW'(yy_reg) + SW'(zz_reg);
    end

    always_comb
    begin
        d3_next.norm  = norm_reg;
        d3_next.degen = (norm_reg == '0);
        for (int i = 0; i < NL; i++)
        begin
            d3_next.neg[i] = num_reg[i][SW-1];
            mag[i] = num_reg[i][SW-1] ? MW'(-num_reg[i]) : MW'(num_reg[i]);
            if (mag[i] >= norm_reg)
            begin
                d3_next.rem[i] = mag[i] - norm_reg;
                d3_next.quo[i] = QW'(1);
            end
            else
            begin
                d3_next.rem[i] = mag[i];
                d3_next.quo[i] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ww_reg <= qw * qw;
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            zz_reg <= qz * qz;
            xy_reg <= qx * qy;
            xz_reg <= qx * qz;
            yz_reg <= qy * qz;
            xw_reg <= qx * qw;
            yw_reg <= qy * qw;
            zw_reg <= qz * qw;
            num_reg  <= num_next;
            norm_reg <= norm_next;
            d3_reg   <= d3_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = d3_reg;

endmodule

>>> rtl/qrm_div_stage.sv
module qrm_div_stage
    import qrm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  div_t in_data,
    output logic out_valid,
    output div_t out_data
);

    div_t          d_reg, d_next;
    logic          v_reg;
    logic [MW-1:0] r2 [NL];

    // one restoring step per lane: double, compare, subtract
    always_comb
    begin
        d_next = in_data;
        for (int i = 0; i < NL; i++)
        begin
            r2[i] = {in_data.rem[i][MW-2:0], 1'b0};
            if (r2[i] >= in_data.norm)
            begin
                d_next.rem[i] = r2[i] - in_data.norm;
                d_next.quo[i] = {in_data.quo[i][QW-2:0], 1'b1};
            end
            else
            begin
                d_next.rem[i] = r2[i];
                d_next.quo[i] = {in_data.quo[i][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_valid;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule

>>> rtl/qrm_back.sv
module qrm_back
    import qrm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   in_valid,
    input  div_t   in_data,
    output logic   out_valid,
    output entry_t ent [NL],
    output logic   degen
);

    entry_t            ent_reg [NL];
    entry_t            ent_next [NL];
    logic              degen_reg;
    logic              v_reg;
    logic [QW-1:0]     qr [NL];
    logic signed [EW-1:0] sv [NL];

    // round half away: quotient carries one extra bit, add one and drop it
    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            qr[i] = (in_data.quo[i] + QW'(1)) >> 1;
            sv[i] = in_data.neg[i] ? -signed'(EW'(qr[i])) : signed'(EW'(qr[i]));
            if (in_data.degen)
            begin
                ent_next[i] = (i == 0 || i == 4 || i == 8) ? IDENT_ONE : '0;
            end
            else
            begin
                ent_next[i] = sat_entry(sv[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ent_reg   <= ent_next;
            degen_reg <= in_data.degen;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_valid;
        end
    end

    assign out_valid = v_reg;
    assign ent       = ent_reg;
    assign degen     = degen_reg;

endmodule

>>> rtl/quaternion_to_rotation_matrix.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+------------------------------------------
// in       | in_valid / in_stall   | qw qx qy qz        (Q2.14, signed 16b)
// out      | out_valid / out_stall | r00..r22 (Q2.14, signed 16b), degenerate
//
// One beat enters per cycle while the output beat is not held. There are three front stages
// for products, sums and the integer quotient bit, FRAC_BITS+1 divider stages and
// one rounding/output stage. FRAC_BITS sets divider depth; the nine lanes run side by side.
// Reset clears only the valid bits; data registers carry no reset.
// A held beat on the output freezes the whole pipeline; in_stall follows at once.
module quaternion_to_rotation_matrix
    import qrm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [IW-1:0] qw,
    input  logic signed [IW-1:0] qx,
    input  logic signed [IW-1:0] qy,
    input  logic signed [IW-1:0] qz,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [OW-1:0] r00,
    output logic signed [OW-1:0] r01,
    output logic signed [OW-1:0] r02,
    output logic signed [OW-1:0] r10,
    output logic signed [OW-1:0] r11,
    output logic signed [OW-1:0] r12,
    output logic signed [OW-1:0] r20,
    output logic signed [OW-1:0] r21,
    output logic signed [OW-1:0] r22,
    output logic                 degenerate
);

    logic   en;
    logic   dv [DIV_STEPS+1];
    div_t   dd [DIV_STEPS+1];
    entry_t ent [NL];

    // advance everything unless the output beat is held
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    qrm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .qw        (qw),
        .qx        (qx),
        .qy        (qy),
        .qz        (qz),
        .out_valid (dv[0]),
        .out_data  (dd[0])
    );

    // one quotient bit per stage
    for (genvar s = 0; s < DIV_STEPS; s++)
    begin : g_div
        qrm_div_stage u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dv[s]),
            .in_data   (dd[s]),
            .out_valid (dv[s+1]),
            .out_data  (dd[s+1])
        );
    end

    qrm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dv[DIV_STEPS]),
        .in_data   (dd[DIV_STEPS]),
        .out_valid (out_valid),
        .ent       (ent),
        .degen     (degenerate)
    );

    // element order is row-major over the 3x3 matrix: ent[0..8] map to r00..r22
    assign r00 = ent[0];
    assign r01 = ent[1];
    assign r02 = ent[2];
    assign r10 = ent[3];
    assign r11 = ent[4];
    assign r12 = ent[5];
    assign r20 = ent[6];
    assign r21 = ent[7];
    assign r22 = ent[8];

    a_degen_offdiag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> r01 == '0 && r12 == '0 && r20 == '0 && r10 == '0)
        else $error("degenerate beat has nonzero off-diagonal entry");

    a_degen_diag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> r00 == IDENT_ONE && r11 == IDENT_ONE && r22 == IDENT_ONE)
        else $error("degenerate beat is not identity");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> r00 <= IDENT_ONE && r00 >= -IDENT_ONE
                   && r21 <= IDENT_ONE && r21 >= -IDENT_ONE)
        else $error("entry outside saturation range");

    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not track held output beat");

endmodule
